FILE: src/prq_pkg.sv
package prq_pkg;

    localparam int NUM_LEVELS_DEF  = 8;
    localparam int QUEUE_DEPTH_DEF = 16;

    typedef enum logic [2:0] {
        K_INS_ACT = 3'd0,
        K_INS_EXP = 3'd1,
        K_POP     = 3'd2,
        K_PEEK    = 3'd3,
        K_QUERY   = 3'd4
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_LEVEL = 2'd1,
        ST_FULL      = 2'd2,
        ST_MISS      = 2'd3
    } t_status;

    // Ring pointer unit operations.
    typedef enum logic [1:0] {
        ALU_PUSH = 2'd0,
        ALU_TAIL = 2'd1,
        ALU_STEP = 2'd2
    } t_alu_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_META,
        S_EVAL,
        S_POP_ID,
        S_SCAN,
        S_RESP
    } t_state;

    typedef struct packed {
        logic re;
        logic we;
    } t_mem_ctl;

endpackage

FILE: src/prq_id_ram.sv
module prq_id_ram #(
    parameter int AW = 8
) (
    input  logic              i_clk,
    input  prq_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  logic [7:0]        i_wdata,
    output logic [7:0]        o_rdata
);

    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rdata <= r_mem[i_addr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/prq_meta_ram.sv
module prq_meta_ram #(
    parameter int AW = 4,
    parameter int DW = 9
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  prq_pkg::t_mem_ctl i_ctl,
    input  logic [AW-1:0]     i_addr,
    input  logic [DW-1:0]     i_wdata,
    output logic [DW-1:0]     o_rdata
);

    // An entry never written since reset reads as zero head and zero count.
    logic [DW-1:0]    r_mem [2**AW];
    logic [2**AW-1:0] r_vld;
    logic [DW-1:0]    r_rd_data;
    logic             r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_ctl.re) begin
            r_rd_data <= r_mem[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.we) begin
                r_vld[i_addr] <= 1'b1;
            end
            if (i_ctl.re) begin
                r_rd_vld <= r_vld[i_addr];
            end
        end
    end

    assign o_rdata = r_rd_vld ? r_rd_data : '0;

endmodule

FILE: src/prq_ring_alu.sv
module prq_ring_alu #(
    parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
    input  prq_pkg::t_alu_op                   i_op,
    input  logic [$clog2(QUEUE_DEPTH)-1:0]     i_ptr,
    input  logic [$clog2(QUEUE_DEPTH+1)-1:0]   i_cnt,
    output logic [$clog2(QUEUE_DEPTH)-1:0]     o_ptr,
    output logic [$clog2(QUEUE_DEPTH+1)-1:0]   o_cnt
);

    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0] DEPTH_W = (CW+1)'(QUEUE_DEPTH);

    logic [CW:0]   ptr_inc;
    logic [CW:0]   tail_sum;
    logic [CW:0]   tail_red;
    logic [SW-1:0] ptr_wrap;
    logic [SW-1:0] ptr_tail;

    always_comb begin
        ptr_inc  = (CW+1)'(i_ptr) + (CW+1)'(1);
        ptr_wrap = (ptr_inc >= DEPTH_W) ? '0 : ptr_inc[SW-1:0];
        // Oldest slot is head minus count, taken modulo the ring depth.
        tail_sum = (CW+1)'(i_ptr) + DEPTH_W - (CW+1)'(i_cnt);
        tail_red = (tail_sum >= DEPTH_W) ? tail_sum - DEPTH_W : tail_sum;
        ptr_tail = tail_red[SW-1:0];

        unique case (i_op)
            prq_pkg::ALU_PUSH: begin
                o_ptr = ptr_wrap;
                o_cnt = i_cnt + CW'(1);
            end
            prq_pkg::ALU_TAIL: begin
                o_ptr = ptr_tail;
                o_cnt = i_cnt - CW'(1);
            end
            default: begin
                o_ptr = ptr_wrap;
                o_cnt = i_cnt - CW'(1);
            end
        endcase
    end

endmodule

FILE: src/prq_ctrl.sv
module prq_ctrl #(
    parameter int NUM_LEVELS  = prq_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF,
    parameter int LW          = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1,
    parameter int SW          = $clog2(QUEUE_DEPTH),
    parameter int CW          = $clog2(QUEUE_DEPTH + 1)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [2:0]           i_kind,
    input  logic [7:0]           i_thread_id,
    input  logic [7:0]           i_level,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [1:0]           o_status,
    output logic [7:0]           o_out_id,
    output logic [3:0]           o_out_level,
    output logic                 o_present,
    output prq_pkg::t_mem_ctl    o_meta_ctl,
    output logic [LW:0]          o_meta_addr,
    output logic [SW+CW-1:0]     o_meta_wdata,
    input  logic [SW+CW-1:0]     i_meta_rdata,
    output prq_pkg::t_mem_ctl    o_id_ctl,
    output logic [LW+SW:0]       o_id_addr,
    output logic [7:0]           o_id_wdata,
    input  logic [7:0]           i_id_rdata,
    output prq_pkg::t_alu_op     o_alu_op,
    output logic [SW-1:0]        o_alu_ptr,
    output logic [CW-1:0]        o_alu_cnt,
    input  logic [SW-1:0]        i_alu_ptr,
    input  logic [CW-1:0]        i_alu_cnt
);

    localparam logic [LW-1:0] LV_TOP = LW'(NUM_LEVELS - 1);

    prq_pkg::t_state  r_state, n_state;
    prq_pkg::t_kind   r_kind, n_kind;
    prq_pkg::t_status r_status, n_status;
    logic [7:0]       r_id, n_id;
    logic             r_set, n_set;
    logic [LW-1:0]    r_lv, n_lv;
    logic [SW-1:0]    r_ptr, n_ptr;
    logic [CW-1:0]    r_rem, n_rem;
    logic [7:0]       r_oid, n_oid;
    logic [3:0]       r_olvl, n_olvl;
    logic             r_present, n_present;
    logic             r_out_valid, n_out_valid;
    logic [1:0]       r_o_status;
    logic [7:0]       r_o_id;
    logic [3:0]       r_o_lvl;
    logic             r_o_present;
    logic             out_load;

    logic [SW-1:0]    m_head;
    logic [CW-1:0]    m_count;
    logic [7:0]       lvl_m1;
    logic [7:0]       lvl_p1;

    assign m_head  = i_meta_rdata[SW+CW-1:CW];
    assign m_count = i_meta_rdata[CW-1:0];
    assign lvl_m1  = i_level - 8'd1;
    assign lvl_p1  = 8'(r_lv) + 8'd1;

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_status     = r_status;
        n_id         = r_id;
        n_set        = r_set;
        n_lv         = r_lv;
        n_ptr        = r_ptr;
        n_rem        = r_rem;
        n_oid        = r_oid;
        n_olvl       = r_olvl;
        n_present    = r_present;
        n_out_valid  = r_out_valid;
        out_load     = 1'b0;
        o_meta_ctl   = '0;
        o_meta_addr  = {r_set, r_lv};
        o_meta_wdata = {m_head, m_count};
        o_id_ctl     = '0;
        o_id_addr    = {r_set, r_lv, i_alu_ptr};
        o_id_wdata   = r_id;
        o_alu_op     = prq_pkg::ALU_TAIL;
        o_alu_ptr    = m_head;
        o_alu_cnt    = m_count;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            prq_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_kind    = prq_pkg::t_kind'(i_kind);
                    n_id      = i_thread_id;
                    n_status  = prq_pkg::ST_OK;
                    n_oid     = '0;
                    n_olvl    = '0;
                    n_present = 1'b0;
                    n_set     = 1'b0;
                    n_lv      = '0;
                    unique case (prq_pkg::t_kind'(i_kind))
                        prq_pkg::K_INS_ACT, prq_pkg::K_INS_EXP: begin
                            if (i_level == 8'd0 || i_level > 8'(NUM_LEVELS)) begin
                                n_status = prq_pkg::ST_BAD_LEVEL;
                                n_state  = prq_pkg::S_RESP;
                            end else begin
                                n_set   = (prq_pkg::t_kind'(i_kind) == prq_pkg::K_INS_EXP);
                                n_lv    = lvl_m1[LW-1:0];
                                n_state = prq_pkg::S_META;
                            end
                        end
                        prq_pkg::K_POP, prq_pkg::K_PEEK: begin
                            n_lv    = LV_TOP;
                            n_state = prq_pkg::S_META;
                        end
                        prq_pkg::K_QUERY: begin
                            n_state = prq_pkg::S_META;
                        end
                        default: begin
                            n_state = prq_pkg::S_RESP;
                        end
                    endcase
                end
            end

            prq_pkg::S_META: begin
                o_meta_ctl.re = 1'b1;
                n_state       = prq_pkg::S_EVAL;
            end

            prq_pkg::S_EVAL: begin
                unique case (r_kind)
                    prq_pkg::K_INS_ACT, prq_pkg::K_INS_EXP: begin
                        o_alu_op = prq_pkg::ALU_PUSH;
                        if (m_count == CW'(QUEUE_DEPTH)) begin
                            n_status = prq_pkg::ST_FULL;
                        end else begin
                            o_id_ctl.we   = 1'b1;
                            o_id_addr     = {r_set, r_lv, m_head};
                            o_meta_ctl.we = 1'b1;
                            o_meta_wdata  = {i_alu_ptr, i_alu_cnt};
                        end
                        n_state = prq_pkg::S_RESP;
                    end
                    prq_pkg::K_POP, prq_pkg::K_PEEK: begin
                        if (m_count != '0) begin
                            o_id_ctl.re = 1'b1;
                            if (r_kind == prq_pkg::K_POP) begin
                                o_meta_ctl.we = 1'b1;
                                o_meta_wdata  = {m_head, i_alu_cnt};
                            end
                            n_state = prq_pkg::S_POP_ID;
                        end else if (r_lv == '0) begin
                            n_status = prq_pkg::ST_MISS;
                            n_state  = prq_pkg::S_RESP;
                        end else begin
                            n_lv    = r_lv - LW'(1);
                            n_state = prq_pkg::S_META;
                        end
                    end
                    prq_pkg::K_QUERY: begin
                        if (m_count != '0) begin
                            o_id_ctl.re = 1'b1;
                            n_ptr       = i_alu_ptr;
                            n_rem       = i_alu_cnt;
                            n_state     = prq_pkg::S_SCAN;
                        end else if (r_lv != LV_TOP) begin
                            n_lv    = r_lv + LW'(1);
                            n_state = prq_pkg::S_META;
                        end else if (!r_set) begin
                            n_set   = 1'b1;
                            n_lv    = '0;
                            n_state = prq_pkg::S_META;
                        end else begin
                            n_status = prq_pkg::ST_MISS;
                            n_state  = prq_pkg::S_RESP;
                        end
                    end
                    default: begin
                        n_state = prq_pkg::S_RESP;
                    end
                endcase
            end

            prq_pkg::S_POP_ID: begin
                n_oid   = i_id_rdata;
                n_olvl  = lvl_p1[3:0];
                n_state = prq_pkg::S_RESP;
            end

            prq_pkg::S_SCAN: begin
                o_alu_op  = prq_pkg::ALU_STEP;
                o_alu_ptr = r_ptr;
                o_alu_cnt = r_rem;
                if (i_id_rdata == r_id) begin
                    n_present = 1'b1;
                    n_state   = prq_pkg::S_RESP;
                end else if (r_rem != '0) begin
                    o_id_ctl.re = 1'b1;
                    n_ptr       = i_alu_ptr;
                    n_rem       = i_alu_cnt;
                end else if (r_lv != LV_TOP) begin
                    n_lv    = r_lv + LW'(1);
                    n_state = prq_pkg::S_META;
                end else if (!r_set) begin
                    n_set   = 1'b1;
                    n_lv    = '0;
                    n_state = prq_pkg::S_META;
                end else begin
                    n_status = prq_pkg::ST_MISS;
                    n_state  = prq_pkg::S_RESP;
                end
            end

            prq_pkg::S_RESP: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = prq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = prq_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prq_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_status  <= n_status;
        r_id      <= n_id;
        r_set     <= n_set;
        r_lv      <= n_lv;
        r_ptr     <= n_ptr;
        r_rem     <= n_rem;
        r_oid     <= n_oid;
        r_olvl    <= n_olvl;
        r_present <= n_present;
        if (out_load) begin
            r_o_status  <= r_status;
            r_o_id      <= r_oid;
            r_o_lvl     <= r_olvl;
            r_o_present <= r_present;
        end
    end

    assign o_in_stall  = (r_state != prq_pkg::S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_status    = r_o_status;
    assign o_out_id    = r_o_id;
    assign o_out_level = r_o_lvl;
    assign o_present   = r_o_present;

    // No storage is written while the sequencer is idle.
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prq_pkg::S_IDLE) |-> (!o_meta_ctl.we && !o_id_ctl.we))
        else $error("storage written while idle");

    // The scan never has more entries left than a ring can hold.
    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prq_pkg::S_SCAN) |-> (r_rem < CW'(QUEUE_DEPTH)))
        else $error("scan remainder out of range");

    // Leaving the response state always presents a result.
    a_resp_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == prq_pkg::S_RESP && n_state == prq_pkg::S_IDLE) |=> o_out_valid)
        else $error("result lost on return to idle");

endmodule

FILE: src/priority_ready_queue_unit.sv
// Channel   Valid         Stall         Payload
// input     i_in_valid    o_in_stall    i_kind, i_thread_id, i_level
// output    o_out_valid   i_out_stall   o_status, o_out_id, o_out_level, o_present
//
// A small sequencer runs one item at a time around a shared ring pointer unit and
// two single-port memories. An insert reads the level's head and count, then writes
// the id and the new head and count; an invalid level goes straight to the result.
// Pop and peek read head and count level by level from the top until one holds an
// entry, then read its oldest id. Query walks the levels of both sets and compares
// the stored ids until one matches, the id memory reading one entry per cycle.
// Reset is synchronous; head/count valid bits clear at once, so no clearing pass.
// A result waits in the output register while the next item is taken; a stalled
// output only holds the sequencer once its next result is ready.
module priority_ready_queue_unit #(
    parameter int NUM_LEVELS  = prq_pkg::NUM_LEVELS_DEF,
    parameter int QUEUE_DEPTH = prq_pkg::QUEUE_DEPTH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_thread_id,
    input  logic [7:0] i_level,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [7:0] o_out_id,
    output logic [3:0] o_out_level,
    output logic       o_present
);

    // Level index, ring slot and count widths.
    localparam int LW = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam int SW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    prq_pkg::t_mem_ctl meta_ctl;
    logic [LW:0]       meta_addr;
    logic [SW+CW-1:0]  meta_wdata;
    logic [SW+CW-1:0]  meta_rdata;
    prq_pkg::t_mem_ctl id_ctl;
    logic [LW+SW:0]    id_addr;
    logic [7:0]        id_wdata;
    logic [7:0]        id_rdata;
    prq_pkg::t_alu_op  alu_op;
    logic [SW-1:0]     alu_ptr_in;
    logic [CW-1:0]     alu_cnt_in;
    logic [SW-1:0]     alu_ptr_out;
    logic [CW-1:0]     alu_cnt_out;

    // Ring storage for both sets, addressed by set, level and slot.
    prq_id_ram #(
        .AW (LW + SW + 1)
    ) u_id_ram (
        .i_clk   (i_clk),
        .i_ctl   (id_ctl),
        .i_addr  (id_addr),
        .i_wdata (id_wdata),
        .o_rdata (id_rdata)
    );

    // Head and count for every level of both sets, packed as one word.
    prq_meta_ram #(
        .AW (LW + 1),
        .DW (SW + CW)
    ) u_meta_ram (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (meta_ctl),
        .i_addr  (meta_addr),
        .i_wdata (meta_wdata),
        .o_rdata (meta_rdata)
    );

    // Shared pointer unit: ring wrap, tail offset and count update.
    prq_ring_alu #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring_alu (
        .i_op  (alu_op),
        .i_ptr (alu_ptr_in),
        .i_cnt (alu_cnt_in),
        .o_ptr (alu_ptr_out),
        .o_cnt (alu_cnt_out)
    );

    // Sequencer, result staging and output register.
    prq_ctrl #(
        .NUM_LEVELS  (NUM_LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .LW          (LW),
        .SW          (SW),
        .CW          (CW)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_kind       (i_kind),
        .i_thread_id  (i_thread_id),
        .i_level      (i_level),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_status     (o_status),
        .o_out_id     (o_out_id),
        .o_out_level  (o_out_level),
        .o_present    (o_present),
        .o_meta_ctl   (meta_ctl),
        .o_meta_addr  (meta_addr),
        .o_meta_wdata (meta_wdata),
        .i_meta_rdata (meta_rdata),
        .o_id_ctl     (id_ctl),
        .o_id_addr    (id_addr),
        .o_id_wdata   (id_wdata),
        .i_id_rdata   (id_rdata),
        .o_alu_op     (alu_op),
        .o_alu_ptr    (alu_ptr_in),
        .o_alu_cnt    (alu_cnt_in),
        .i_alu_ptr    (alu_ptr_out),
        .i_alu_cnt    (alu_cnt_out)
    );

endmodule
